>>> sv/spcd_pkg.sv
// Shared types, constants and helpers for the sparse precision coordinate descent core.
// Used by spcd_mac, spcd_divsqrt and sparse_precision_coordinate_descent_core.
// No dependencies.
package spcd_pkg;

    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 24;
    localparam int ACC_W         = 48;
    localparam int REG_AW        = 4;

    localparam logic [1:0] REG_DIMENSION  = 2'd0;
    localparam logic [1:0] REG_TOLERANCE  = 2'd1;
    localparam logic [1:0] REG_MAX_SWEEPS = 2'd2;

    localparam logic [3:0]  DIM_RESET    = 4'd8;
    localparam logic [30:0] TOL_RESET    = 31'd16777;
    localparam logic [15:0] SWEEPS_RESET = 16'd100;

    localparam logic [6:0] DIV_STEPS  = 7'd64;
    localparam logic [6:0] SQRT_STEPS = 7'd32;

    typedef enum logic [1:0] {
        ACT_LOAD_COV = 2'd0,
        ACT_LOAD_PEN = 2'd1,
        ACT_LOAD_EST = 2'd2,
        ACT_START    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PH_S1,
        PH_S2,
        PH_DIAG
    } phase_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHK_RD,
        ST_CHK_EV,
        ST_SWEEP_GO,
        ST_TERM_RD,
        ST_TERM_MUL,
        ST_TERM_ACC,
        ST_SUM_DONE,
        ST_PAIR_T,
        ST_PAIR_GO,
        ST_SQ_MUL,
        ST_SQ_SUM,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_DIAG_GO,
        ST_DIV_WAIT,
        ST_UPDATE,
        ST_WRITE2,
        ST_NEXT,
        ST_SWEEP_END,
        ST_OUT_GO,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

    typedef enum logic {
        DS_DIV,
        DS_SQRT
    } ds_op_t;

    typedef struct packed {
        logic   start;
        ds_op_t op;
    } ds_ctl_t;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic first;
        logic sub;
    } mac_ctl_t;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sd2147483647);
        lo = -hi - ACC_W'(1);
        if (x > hi) begin
            return 32'sh7FFFFFFF;
        end else if (x < lo) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

endpackage

>>> sv/spcd_mac.sv
// Shared multiplier with a rounding accumulator for the coordinate descent core.
// Depends on spcd_pkg.
module spcd_mac #(
    parameter int FRAC_BITS = spcd_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  spcd_pkg::mac_ctl_t                 ctl,
    input  logic signed [31:0]                 a,
    input  logic signed [31:0]                 b,
    output logic signed [63:0]                 prod,
    output logic signed [spcd_pkg::ACC_W-1:0]  acc
);

    logic signed [63:0]                prod_reg;
    logic signed [spcd_pkg::ACC_W-1:0] acc_reg;
    logic signed [63:0]                rsum;
    logic signed [63:0]                term;
    logic signed [spcd_pkg::ACC_W-1:0] base;

    // The product is rounded to the fraction grid, floor after adding half an LSB.
    assign rsum = prod_reg + (64'sd1 <<< (FRAC_BITS - 1));
    assign term = rsum >>> FRAC_BITS;
    assign base = ctl.first ? '0 : acc_reg;

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= 64'(a) * 64'(b);
        end
        if (ctl.acc_en) begin
            if (ctl.sub) begin
                acc_reg <= base - term[spcd_pkg::ACC_W-1:0];
            end else begin
                acc_reg <= base + term[spcd_pkg::ACC_W-1:0];
            end
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

>>> sv/spcd_divsqrt.sv
// Iterative divider and integer square root sharing one subtractor.
// Division takes 64 steps, square root 32 steps. Depends on spcd_pkg.
module spcd_divsqrt (
    input  logic              aclk,
    input  logic              aresetn,
    input  spcd_pkg::ds_ctl_t ctl,
    input  logic [63:0]       a,
    input  logic [33:0]       b,
    output logic              busy,
    output logic              done,
    output logic [63:0]       result
);

    spcd_pkg::ds_op_t op_reg;
    logic [6:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [63:0]      x_reg;
    logic [63:0]      y_reg;
    logic [63:0]      bit_reg;
    logic [33:0]      b_reg;
    logic [64:0]      opa;
    logic [64:0]      opb;
    logic [64:0]      diff;
    logic             ge;

    // Division: x holds the partial remainder, y shifts dividend bits out and quotient bits in.
    // Root: x holds the radicand rest, y the root, and the root and bit never overlap.
    always_comb begin
        if (op_reg == spcd_pkg::DS_DIV) begin
            opa = {30'b0, x_reg[33:0], y_reg[63]};
            opb = {31'b0, b_reg};
        end else begin
            opa = {1'b0, x_reg};
            opb = {1'b0, y_reg | bit_reg};
        end
        diff = opa - opb;
        ge   = ~diff[64];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= (ctl.op == spcd_pkg::DS_DIV) ? spcd_pkg::DIV_STEPS
                                                         : spcd_pkg::SQRT_STEPS;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            op_reg  <= ctl.op;
            b_reg   <= b;
            bit_reg <= 64'd1 << 62;
            if (ctl.op == spcd_pkg::DS_DIV) begin
                x_reg <= '0;
                y_reg <= a;
            end else begin
                x_reg <= a;
                y_reg <= '0;
            end
        end else if (busy_reg) begin
            if (op_reg == spcd_pkg::DS_DIV) begin
                x_reg <= ge ? {30'b0, diff[33:0]} : {30'b0, opa[33:0]};
                y_reg <= {y_reg[62:0], ge};
            end else begin
                if (ge) begin
                    x_reg <= diff[63:0];
                    y_reg <= (y_reg >> 1) | bit_reg;
                end else begin
                    y_reg <= y_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = y_reg;

endmodule

>>> sv/sparse_precision_coordinate_descent_core.sv
// Sparse precision matrix estimator by coordinate descent: sequencer, stores, control port.
// Depends on spcd_pkg, spcd_mac and spcd_divsqrt.
//
// Usage: load items on the s_ channel (tuser = action) write covariance, penalty and
// start estimate entries, one item per cycle, with no result. A start item runs
// coordinate descent sweeps and then returns one result per upper-triangle entry on
// the m_ channel, row-major, with tlast on the final one. A start that finds a
// nonpositive covariance diagonal returns a single result with tuser (status) set.
// Configuration (dimension, tolerance, max_sweeps) is written over the APB-style port
// at byte addresses 0, 4 and 8; the user must write it only while the block is idle,
// as the block itself does not enforce this. The start item holds s_tready low until
// its last result is taken. Each multiply-accumulate term passes through the read,
// multiply and accumulate states on the single multiplier; each pair needs 2*(d+1)
// terms plus, unless the result saturates, a 64-step division, each diagonal entry
// d+1 terms, a 32-step square root and a 64-step division. Results leave from an
// output register; a stall simply holds the current result. Reset returns the
// sequencer to idle and restores the register defaults; the stores keep their contents.
module sparse_precision_coordinate_descent_core #(
    parameter int MAX_DIM   = spcd_pkg::MAX_DIM_DEF,
    parameter int FRAC_BITS = spcd_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // s_tdata: row[2:0], col[5:3], value[37:6], zero[39:38]
    input  logic [39:0]                 s_tdata,
    // s_tuser: action[1:0]
    input  logic [1:0]                  s_tuser,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // m_tdata: out_row[2:0], out_col[5:3], estimate[37:6], sweeps_done[53:38],
    //          converged[54], zero[55]
    output logic [55:0]                 m_tdata,
    // m_tuser: status[0]
    output logic                        m_tuser,
    output logic                        m_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spcd_pkg::REG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int SQ_DEPTH  = MAX_DIM * MAX_DIM;
    localparam int TRI_DEPTH = MAX_DIM * (MAX_DIM + 1) / 2;
    localparam int SQ_AW     = $clog2(SQ_DEPTH);
    localparam int TRI_AW    = $clog2(TRI_DEPTH);
    localparam int CW        = $clog2(MAX_DIM + 1);

    function automatic logic [SQ_AW-1:0] sq_addr(input int r, input int c);
        int v;
        v = r * MAX_DIM + c;
        return v[SQ_AW-1:0];
    endfunction

    function automatic logic [TRI_AW-1:0] tri_addr(input int r, input int c);
        int lo;
        int hi;
        int v;
        lo = (r < c) ? r : c;
        hi = (r < c) ? c : r;
        v  = MAX_DIM * lo + hi - ((lo * (lo + 1)) >> 1);
        return v[TRI_AW-1:0];
    endfunction

    // Configuration registers.
    logic [3:0]  dim_reg;
    logic [30:0] tol_reg;
    logic [15:0] max_sweeps_reg;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg        <= spcd_pkg::DIM_RESET;
            tol_reg        <= spcd_pkg::TOL_RESET;
            max_sweeps_reg <= spcd_pkg::SWEEPS_RESET;
        end else if (cfg_we) begin
            case (paddr[3:2])
                spcd_pkg::REG_DIMENSION:  dim_reg        <= pwdata[3:0];
                spcd_pkg::REG_TOLERANCE:  tol_reg        <= pwdata[30:0];
                spcd_pkg::REG_MAX_SWEEPS: max_sweeps_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            spcd_pkg::REG_DIMENSION:  prdata = {28'b0, dim_reg};
            spcd_pkg::REG_TOLERANCE:  prdata = {1'b0, tol_reg};
            spcd_pkg::REG_MAX_SWEEPS: prdata = {16'b0, max_sweeps_reg};
            default:                  prdata = '0;
        endcase
    end

    logic [CW-1:0] d;
    always_comb begin
        if (dim_reg < 4'd2) begin
            d = CW'(2);
        end else if (int'(dim_reg) > MAX_DIM) begin
            d = CW'(MAX_DIM);
        end else begin
            d = dim_reg[CW-1:0];
        end
    end

    // Input fields.
    spcd_pkg::action_t  in_action;
    logic [2:0]         in_row;
    logic [2:0]         in_col;
    logic signed [31:0] in_value;
    logic               in_acc;
    logic               load_ok;

    assign in_action = spcd_pkg::action_t'(s_tuser);
    assign in_row    = s_tdata[2:0];
    assign in_col    = s_tdata[5:3];
    assign in_value  = s_tdata[37:6];
    assign in_acc    = s_tvalid & s_tready;
    assign load_ok   = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);

    // Sequencer state.
    spcd_pkg::state_t   state_reg;
    spcd_pkg::state_t   state_next;
    spcd_pkg::phase_t   phase_reg;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      j_reg;
    logic [CW-1:0]      k_reg;
    logic [15:0]        sweeps_reg;
    logic               conv_reg;
    logic [32:0]        maxdiff_reg;
    logic signed [31:0] s1_reg;
    logic signed [31:0] s2_reg;
    logic signed [31:0] cii_reg;
    logic signed [31:0] cjj_reg;
    logic signed [31:0] cb_reg;
    logic signed [31:0] lam_reg;
    logic signed [31:0] prev_reg;
    logic signed [34:0] t_reg;
    logic               neg_reg;
    logic signed [31:0] nv_reg;
    logic [63:0]        sq_in_reg;

    // Output register.
    logic               m_tvalid_reg;
    logic [2:0]         orow_reg;
    logic [2:0]         ocol_reg;
    logic signed [31:0] oest_reg;
    logic [15:0]        osweeps_reg;
    logic               oconv_reg;
    logic               ostatus_reg;
    logic               olast_reg;

    // Stores.
    logic signed [31:0] cov_mem  [SQ_DEPTH];
    logic signed [31:0] est_mem  [SQ_DEPTH];
    logic signed [31:0] pen_mem  [TRI_DEPTH];
    logic signed [31:0] prev_mem [TRI_DEPTH];
    logic signed [31:0] cov_rd_reg;
    logic signed [31:0] est_rd_reg;
    logic signed [31:0] pen_rd_reg;
    logic signed [31:0] prev_rd_reg;

    logic [SQ_AW-1:0]   cov_raddr;
    logic [SQ_AW-1:0]   est_raddr;
    logic [SQ_AW-1:0]   est_waddr;
    logic signed [31:0] est_wdata;
    logic               est_we;
    logic               cov_we;
    logic               pen_we;
    logic               prev_we;
    logic [TRI_AW-1:0]  tri_cur;
    logic [SQ_AW-1:0]   load_sq;
    logic [TRI_AW-1:0]  load_tri;

    // Shared units.
    spcd_pkg::mac_ctl_t                mac_ctl;
    logic signed [31:0]                mac_a;
    logic signed [31:0]                mac_b;
    logic signed [63:0]                mac_prod;
    logic signed [spcd_pkg::ACC_W-1:0] mac_acc;
    spcd_pkg::ds_ctl_t                 ds_ctl;
    logic [63:0]                       ds_a;
    logic [33:0]                       ds_b;
    logic                              ds_busy;
    logic                              ds_done;
    logic [63:0]                       ds_result;

    spcd_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .aclk (aclk),
        .ctl  (mac_ctl),
        .a    (mac_a),
        .b    (mac_b),
        .prod (mac_prod),
        .acc  (mac_acc)
    );

    spcd_divsqrt u_divsqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ds_ctl),
        .a       (ds_a),
        .b       (ds_b),
        .busy    (ds_busy),
        .done    (ds_done),
        .result  (ds_result)
    );

    // Row pair of the current accumulation pass.
    logic [CW-1:0] ra;
    logic [CW-1:0] rb;
    always_comb begin
        case (phase_reg)
            spcd_pkg::PH_S1: begin
                ra = i_reg;
                rb = j_reg;
            end
            spcd_pkg::PH_S2: begin
                ra = j_reg;
                rb = i_reg;
            end
            default: begin
                ra = i_reg;
                rb = i_reg;
            end
        endcase
    end

    logic k_last;
    logic out_last;
    assign k_last   = (k_reg == d);
    assign out_last = (int'(i_reg) == int'(d) - 1) && (int'(j_reg) == int'(d) - 1);
    assign tri_cur  = tri_addr(int'(i_reg), int'(j_reg));
    assign load_sq  = sq_addr(int'(in_row), int'(in_col));
    assign load_tri = tri_addr(int'(in_row), int'(in_col));

    // Pair update: soft threshold and the overflow test ahead of the division.
    logic signed [33:0] pair_sum;
    logic signed [34:0] num_x;
    logic signed [34:0] lam_x;
    logic signed [34:0] am;
    logic signed [34:0] t_new;
    logic [34:0]        t_mag;
    logic [32:0]        den;
    logic [63:0]        pair_lim;
    logic               pair_ovf;

    always_comb begin
        pair_sum = 34'(s1_reg) + 34'(s2_reg);
        num_x    = -35'(pair_sum);
        lam_x    = 35'(lam_reg);
        am       = (num_x < 0) ? -num_x : num_x;
        if (lam_x < am) begin
            t_new = (num_x > 0) ? (num_x - lam_x) : (num_x + lam_x);
        end else begin
            t_new = '0;
        end
        t_mag    = (t_reg < 0) ? 35'(-t_reg) : 35'(t_reg);
        den      = {1'b0, cii_reg} + {1'b0, cjj_reg};
        pair_lim = {31'b0, den} << (31 - FRAC_BITS);
        pair_ovf = ({29'b0, t_mag} >= pair_lim);
    end

    // Diagonal update: operands of the root division.
    logic [32:0]        root;
    logic [32:0]        neg_s;
    logic [33:0]        nn;
    logic [33:0]        den2;
    logic               s_le0;
    logic [63:0]        diag_a;
    logic [33:0]        diag_b;
    logic [63:0]        sq_in_new;

    always_comb begin
        root      = ds_result[32:0];
        s_le0     = (s2_reg <= 0);
        neg_s     = 33'(-33'(s2_reg));
        nn        = {1'b0, neg_s} + {1'b0, root};
        den2      = {2'b0, s2_reg} + {1'b0, root};
        if (s_le0) begin
            diag_a = ({30'b0, nn} << FRAC_BITS) + {32'b0, cii_reg};
            diag_b = {1'b0, cii_reg, 1'b0};
        end else begin
            diag_a = (64'd1 << (2 * FRAC_BITS + 1)) + {31'b0, den2[33:1]};
            diag_b = den2;
        end
        sq_in_new = 64'(mac_prod) + ({32'b0, cii_reg} << (FRAC_BITS + 2));
    end

    // New value after the division, and its change against the previous sweep.
    logic signed [31:0] div_nv;
    logic signed [31:0] ident;
    logic signed [31:0] prev_val;
    logic signed [32:0] df_s;
    logic [32:0]        df;
    logic               conv_now;

    always_comb begin
        if (phase_reg == spcd_pkg::PH_DIAG) begin
            div_nv = (ds_result > 64'd2147483647) ? 32'sh7FFFFFFF : ds_result[31:0];
        end else begin
            div_nv = neg_reg ? -ds_result[31:0] : ds_result[31:0];
        end
        ident    = (i_reg == j_reg) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
        prev_val = (sweeps_reg == 16'd0) ? ident : prev_reg;
        df_s     = 33'(prev_val) - 33'(nv_reg);
        df       = (df_s < 0) ? 33'(-df_s) : 33'(df_s);
        conv_now = (maxdiff_reg < {2'b0, tol_reg});
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            spcd_pkg::ST_IDLE: begin
                if (in_acc && in_action == spcd_pkg::ACT_START) begin
                    state_next = spcd_pkg::ST_CHK_RD;
                end
            end
            spcd_pkg::ST_CHK_RD: state_next = spcd_pkg::ST_CHK_EV;
            spcd_pkg::ST_CHK_EV: begin
                if (cov_rd_reg <= 0) begin
                    state_next = spcd_pkg::ST_OUT_WAIT;
                end else if (int'(i_reg) + 1 < int'(d)) begin
                    state_next = spcd_pkg::ST_CHK_RD;
                end else if (max_sweeps_reg == 16'd0) begin
                    state_next = spcd_pkg::ST_OUT_GO;
                end else begin
                    state_next = spcd_pkg::ST_SWEEP_GO;
                end
            end
            spcd_pkg::ST_SWEEP_GO: state_next = spcd_pkg::ST_TERM_RD;
            spcd_pkg::ST_TERM_RD:  state_next = spcd_pkg::ST_TERM_MUL;
            spcd_pkg::ST_TERM_MUL: state_next = spcd_pkg::ST_TERM_ACC;
            spcd_pkg::ST_TERM_ACC: begin
                state_next = k_last ? spcd_pkg::ST_SUM_DONE : spcd_pkg::ST_TERM_RD;
            end
            spcd_pkg::ST_SUM_DONE: begin
                case (phase_reg)
                    spcd_pkg::PH_S1: state_next = spcd_pkg::ST_TERM_RD;
                    spcd_pkg::PH_S2: state_next = spcd_pkg::ST_PAIR_T;
                    default:         state_next = spcd_pkg::ST_SQ_MUL;
                endcase
            end
            spcd_pkg::ST_PAIR_T: state_next = spcd_pkg::ST_PAIR_GO;
            spcd_pkg::ST_PAIR_GO: begin
                state_next = pair_ovf ? spcd_pkg::ST_UPDATE : spcd_pkg::ST_DIV_WAIT;
            end
            spcd_pkg::ST_SQ_MUL:  state_next = spcd_pkg::ST_SQ_SUM;
            spcd_pkg::ST_SQ_SUM:  state_next = spcd_pkg::ST_SQRT_GO;
            spcd_pkg::ST_SQRT_GO: state_next = spcd_pkg::ST_SQRT_WAIT;
            spcd_pkg::ST_SQRT_WAIT: begin
                if (ds_done) begin
                    state_next = spcd_pkg::ST_DIAG_GO;
                end
            end
            spcd_pkg::ST_DIAG_GO: state_next = spcd_pkg::ST_DIV_WAIT;
            spcd_pkg::ST_DIV_WAIT: begin
                if (ds_done) begin
                    state_next = spcd_pkg::ST_UPDATE;
                end
            end
            spcd_pkg::ST_UPDATE: begin
                state_next = (phase_reg == spcd_pkg::PH_DIAG) ? spcd_pkg::ST_NEXT
                                                              : spcd_pkg::ST_WRITE2;
            end
            spcd_pkg::ST_WRITE2: state_next = spcd_pkg::ST_NEXT;
            spcd_pkg::ST_NEXT: begin
                if (phase_reg == spcd_pkg::PH_DIAG && int'(i_reg) + 1 >= int'(d)) begin
                    state_next = spcd_pkg::ST_SWEEP_END;
                end else begin
                    state_next = spcd_pkg::ST_TERM_RD;
                end
            end
            spcd_pkg::ST_SWEEP_END: begin
                if ((17'(sweeps_reg) + 17'd1 < 17'(max_sweeps_reg)) && !conv_now) begin
                    state_next = spcd_pkg::ST_SWEEP_GO;
                end else begin
                    state_next = spcd_pkg::ST_OUT_GO;
                end
            end
            spcd_pkg::ST_OUT_GO: state_next = spcd_pkg::ST_OUT_RD;
            spcd_pkg::ST_OUT_RD: state_next = spcd_pkg::ST_OUT_LD;
            spcd_pkg::ST_OUT_LD: state_next = spcd_pkg::ST_OUT_WAIT;
            spcd_pkg::ST_OUT_WAIT: begin
                if (m_tready) begin
                    state_next = olast_reg ? spcd_pkg::ST_IDLE : spcd_pkg::ST_OUT_RD;
                end
            end
            default: state_next = spcd_pkg::ST_IDLE;
        endcase
    end

    // Control outputs: store ports and unit commands.
    always_comb begin
        cov_raddr = '0;
        est_raddr = '0;
        est_waddr = '0;
        est_wdata = nv_reg;
        est_we    = 1'b0;
        cov_we    = 1'b0;
        pen_we    = 1'b0;
        prev_we   = 1'b0;
        mac_ctl   = '0;
        mac_a     = est_rd_reg;
        mac_b     = cov_rd_reg;
        ds_ctl    = '{start: 1'b0, op: spcd_pkg::DS_DIV};
        ds_a      = diag_a;
        ds_b      = diag_b;
        case (state_reg)
            spcd_pkg::ST_IDLE: begin
                if (in_acc && load_ok) begin
                    cov_we    = (in_action == spcd_pkg::ACT_LOAD_COV);
                    pen_we    = (in_action == spcd_pkg::ACT_LOAD_PEN);
                    est_we    = (in_action == spcd_pkg::ACT_LOAD_EST);
                    est_waddr = load_sq;
                    est_wdata = in_value;
                end
            end
            spcd_pkg::ST_CHK_RD: cov_raddr = sq_addr(int'(i_reg), int'(i_reg));
            spcd_pkg::ST_TERM_RD: begin
                if (k_last) begin
                    est_raddr = sq_addr(int'(i_reg), int'(j_reg));
                    cov_raddr = sq_addr(int'(rb), int'(rb));
                end else begin
                    est_raddr = sq_addr(int'(ra), int'(k_reg));
                    cov_raddr = sq_addr(int'(rb), int'(k_reg));
                end
            end
            spcd_pkg::ST_TERM_MUL: mac_ctl.mul_en = 1'b1;
            spcd_pkg::ST_TERM_ACC: begin
                mac_ctl.acc_en = 1'b1;
                mac_ctl.first  = (k_reg == '0);
                mac_ctl.sub    = k_last;
            end
            spcd_pkg::ST_PAIR_GO: begin
                ds_ctl = '{start: ~pair_ovf, op: spcd_pkg::DS_DIV};
                ds_a   = ({29'b0, t_mag} << FRAC_BITS) + {32'b0, den[32:1]};
                ds_b   = {1'b0, den};
            end
            spcd_pkg::ST_SQ_MUL: begin
                mac_ctl.mul_en = 1'b1;
                mac_a          = s2_reg;
                mac_b          = s2_reg;
            end
            spcd_pkg::ST_SQRT_GO: begin
                ds_ctl = '{start: 1'b1, op: spcd_pkg::DS_SQRT};
                ds_a   = sq_in_reg;
            end
            spcd_pkg::ST_DIAG_GO: ds_ctl = '{start: 1'b1, op: spcd_pkg::DS_DIV};
            spcd_pkg::ST_UPDATE: begin
                est_we    = 1'b1;
                est_waddr = sq_addr(int'(i_reg), int'(j_reg));
                prev_we   = 1'b1;
            end
            spcd_pkg::ST_WRITE2: begin
                est_we    = 1'b1;
                est_waddr = sq_addr(int'(j_reg), int'(i_reg));
            end
            spcd_pkg::ST_OUT_RD: est_raddr = sq_addr(int'(i_reg), int'(j_reg));
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cov_we) begin
            cov_mem[load_sq] <= in_value;
        end
        if (est_we) begin
            est_mem[est_waddr] <= est_wdata;
        end
        if (pen_we) begin
            pen_mem[load_tri] <= in_value;
        end
        if (prev_we) begin
            prev_mem[tri_cur] <= nv_reg;
        end
        cov_rd_reg  <= cov_mem[cov_raddr];
        est_rd_reg  <= est_mem[est_raddr];
        pen_rd_reg  <= pen_mem[tri_cur];
        prev_rd_reg <= prev_mem[tri_cur];
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= spcd_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == spcd_pkg::ST_CHK_EV && cov_rd_reg <= 0) begin
                m_tvalid_reg <= 1'b1;
            end else if (state_reg == spcd_pkg::ST_OUT_LD) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Sequencer datapath.
    always_ff @(posedge aclk) begin
        case (state_reg)
            spcd_pkg::ST_IDLE: begin
                i_reg <= '0;
            end
            spcd_pkg::ST_CHK_EV: begin
                if (cov_rd_reg <= 0) begin
                    orow_reg    <= '0;
                    ocol_reg    <= '0;
                    oest_reg    <= '0;
                    osweeps_reg <= '0;
                    oconv_reg   <= 1'b0;
                    ostatus_reg <= 1'b1;
                    olast_reg   <= 1'b1;
                end else begin
                    i_reg <= i_reg + CW'(1);
                end
                sweeps_reg  <= '0;
                conv_reg    <= 1'b0;
                maxdiff_reg <= '0;
            end
            spcd_pkg::ST_SWEEP_GO: begin
                i_reg     <= '0;
                j_reg     <= CW'(1);
                k_reg     <= '0;
                phase_reg <= spcd_pkg::PH_S1;
            end
            spcd_pkg::ST_TERM_MUL: begin
                if (k_last) begin
                    cb_reg <= cov_rd_reg;
                end
                lam_reg  <= pen_rd_reg;
                prev_reg <= prev_rd_reg;
            end
            spcd_pkg::ST_TERM_ACC: begin
                if (!k_last) begin
                    k_reg <= k_reg + CW'(1);
                end
            end
            spcd_pkg::ST_SUM_DONE: begin
                if (phase_reg == spcd_pkg::PH_S1) begin
                    s1_reg    <= spcd_pkg::sat32(mac_acc);
                    cjj_reg   <= cb_reg;
                    phase_reg <= spcd_pkg::PH_S2;
                    k_reg     <= '0;
                end else begin
                    s2_reg  <= spcd_pkg::sat32(mac_acc);
                    cii_reg <= cb_reg;
                end
            end
            spcd_pkg::ST_PAIR_T: begin
                t_reg <= t_new;
            end
            spcd_pkg::ST_PAIR_GO: begin
                neg_reg <= (t_reg < 0);
                if (pair_ovf) begin
                    nv_reg <= (t_reg < 0) ? 32'sh80000000 : 32'sh7FFFFFFF;
                end
            end
            spcd_pkg::ST_SQ_SUM: begin
                sq_in_reg <= sq_in_new;
            end
            spcd_pkg::ST_DIV_WAIT: begin
                if (ds_done) begin
                    nv_reg <= div_nv;
                end
            end
            spcd_pkg::ST_UPDATE: begin
                if (df > maxdiff_reg) begin
                    maxdiff_reg <= df;
                end
            end
            spcd_pkg::ST_NEXT: begin
                k_reg <= '0;
                if (phase_reg == spcd_pkg::PH_DIAG) begin
                    i_reg <= i_reg + CW'(1);
                    j_reg <= i_reg + CW'(1);
                end else if (int'(j_reg) + 1 < int'(d)) begin
                    j_reg     <= j_reg + CW'(1);
                    phase_reg <= spcd_pkg::PH_S1;
                end else if (int'(i_reg) + 2 < int'(d)) begin
                    i_reg     <= i_reg + CW'(1);
                    j_reg     <= i_reg + CW'(2);
                    phase_reg <= spcd_pkg::PH_S1;
                end else begin
                    i_reg     <= '0;
                    j_reg     <= '0;
                    phase_reg <= spcd_pkg::PH_DIAG;
                end
            end
            spcd_pkg::ST_SWEEP_END: begin
                sweeps_reg  <= sweeps_reg + 16'd1;
                conv_reg    <= conv_now;
                maxdiff_reg <= '0;
            end
            spcd_pkg::ST_OUT_GO: begin
                i_reg <= '0;
                j_reg <= '0;
            end
            spcd_pkg::ST_OUT_LD: begin
                orow_reg    <= 3'(i_reg);
                ocol_reg    <= 3'(j_reg);
                oest_reg    <= est_rd_reg;
                osweeps_reg <= sweeps_reg;
                oconv_reg   <= conv_reg;
                ostatus_reg <= 1'b0;
                olast_reg   <= out_last;
            end
            spcd_pkg::ST_OUT_WAIT: begin
                if (m_tready) begin
                    if (int'(j_reg) + 1 < int'(d)) begin
                        j_reg <= j_reg + CW'(1);
                    end else begin
                        i_reg <= i_reg + CW'(1);
                        j_reg <= i_reg + CW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == spcd_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, oconv_reg, osweeps_reg, oest_reg, ocol_reg, orow_reg};
    assign m_tuser  = ostatus_reg;
    assign m_tlast  = olast_reg;

`ifndef ASSERT_OFF
    a_refused_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("refused result without tlast");

    a_no_input_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input accepted while a result is pending");

    a_unit_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ds_ctl.start |-> !ds_busy)
        else $error("divider started while busy");

    a_converged_has_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser && m_tdata[54] |-> m_tdata[53:38] != 16'd0)
        else $error("converged flag without a sweep");
`endif

endmodule
